// ===== design/ascii_lrc_frame_receiver_defines.svh =====
// Assertion macros for the ASCII LRC frame receiver.
`ifndef ASCII_LRC_FRAME_RECEIVER_DEFINES_SVH
`define ASCII_LRC_FRAME_RECEIVER_DEFINES_SVH

`ifndef SYNTHESIS

`define ALRC_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) prop) \
    else $error("alrc assertion failed");

`define ALRC_ASSERT_NEVER(lbl, clk, rstn, expr) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(expr)) \
    else $error("alrc forbidden condition");

`else

`define ALRC_ASSERT(lbl, clk, rstn, prop)

`define ALRC_ASSERT_NEVER(lbl, clk, rstn, expr)

`endif

`endif

// ===== design/alrc_pkg.sv =====
// Shared types, constants and helpers for the ASCII LRC frame receiver.
package alrc_pkg;

  localparam logic [7:0] ChLf    = 8'h0a;
  localparam logic [7:0] ChColon = 8'h3a;
  localparam int unsigned HistDepth = 3;
  localparam logic [1:0] HistFull = 2'd3;
  localparam logic [7:0] CountMax = 8'hff;

  localparam logic [7:0] Ch0     = 8'h30;
  localparam logic [7:0] Ch9     = 8'h39;
  localparam logic [7:0] ChLowA  = 8'h61;
  localparam logic [7:0] ChLowF  = 8'h66;
  localparam logic [7:0] ChUpA   = 8'h41;
  localparam logic [7:0] ChUpF   = 8'h46;
  localparam logic [7:0] HexTen  = 8'd10;

  localparam logic RegAcceptZeroLrc = 1'b0;  // register index, paddr[2]
  localparam int unsigned TdataW = 40;

  typedef struct packed {
    logic       payload_valid;
    logic [7:0] payload_byte;
    logic       frame_end;
    logic       frame_ok;
    logic [7:0] received_lrc;
    logic [7:0] computed_lrc;
    logic [7:0] payload_length;
  } result_t;

  // {not_hex, value}
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [7:0] v;
    logic       bad;
    begin
      v   = 8'd0;
      bad = 1'b0;
      if (c >= Ch0 && c <= Ch9) begin
        v = c - Ch0;
      end else if (c >= ChLowA && c <= ChLowF) begin
        v = c - ChLowA + HexTen;
      end else if (c >= ChUpA && c <= ChUpF) begin
        v = c - ChUpA + HexTen;
      end else begin
        bad = 1'b1;
      end
      hex_digit = {bad, v[3:0]};
    end
  endfunction

endpackage

// ===== design/alrc_in_reg.sv =====
// Input register stage holding one received character.
module alrc_in_reg (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_valid_i,
  output logic       s_ready_o,
  input  logic [7:0] s_data_i,
  input  logic       advance_i,
  output logic       valid_o,
  output logic [7:0] data_o
);

  logic       valid_q, valid_d;
  logic [7:0] data_q;
  logic       take;

  assign s_ready_o = !valid_q || advance_i;
  assign take      = s_valid_i && s_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (take) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      data_q <= s_data_i;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ===== design/alrc_core.sv =====
// Frame state (history, sum, count) and per-character result logic.
module alrc_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                advance_i,
  input  logic [7:0]          rx_byte_i,
  input  logic                accept_zero_lrc_i,
  output alrc_pkg::result_t   result_o
);

  logic [7:0] sum_q, sum_d;
  logic [7:0] hist_q [alrc_pkg::HistDepth];
  logic [7:0] hist_d [alrc_pkg::HistDepth];
  logic [1:0] cnt_q, cnt_d;
  logic [7:0] len_q, len_d;

  logic [4:0] hi_dig, lo_dig;
  logic [7:0] rx_lrc, calc_lrc;

  assign hi_dig   = alrc_pkg::hex_digit(hist_q[0]);
  assign lo_dig   = alrc_pkg::hex_digit(hist_q[1]);
  assign rx_lrc   = {hi_dig[3:0], lo_dig[3:0]};
  assign calc_lrc = 8'd0 - sum_q;

  always_comb begin
    result_o = '0;
    sum_d    = sum_q;
    hist_d   = hist_q;
    cnt_d    = cnt_q;
    len_d    = len_q;
    if (rx_byte_i == alrc_pkg::ChColon) begin
      sum_d  = '0;
      hist_d = '{default: '0};
      cnt_d  = '0;
      len_d  = '0;
    end else if (rx_byte_i == alrc_pkg::ChLf) begin
      result_o.frame_end      = 1'b1;
      result_o.computed_lrc   = calc_lrc;
      result_o.payload_length = len_q;
      if (cnt_q == alrc_pkg::HistFull && !hi_dig[4] && !lo_dig[4]) begin
        result_o.received_lrc = rx_lrc;
        result_o.frame_ok     = (rx_lrc == calc_lrc) ||
                                (accept_zero_lrc_i && rx_lrc == 8'd0);
      end
      sum_d  = '0;
      hist_d = '{default: '0};
      cnt_d  = '0;
      len_d  = '0;
    end else if (cnt_q == alrc_pkg::HistFull) begin
      hist_d[0] = hist_q[1];
      hist_d[1] = hist_q[2];
      hist_d[2] = rx_byte_i;
      sum_d     = sum_q + hist_q[0];
      if (len_q != alrc_pkg::CountMax) begin
        len_d = len_q + 8'd1;
      end
      result_o.payload_valid  = 1'b1;
      result_o.payload_byte   = hist_q[0];
      result_o.computed_lrc   = 8'd0 - sum_d;
      result_o.payload_length = len_d;
    end else begin
      hist_d[cnt_q]           = rx_byte_i;
      cnt_d                   = cnt_q + 2'd1;
      result_o.computed_lrc   = calc_lrc;
      result_o.payload_length = len_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q  <= '0;
      hist_q <= '{default: '0};
      cnt_q  <= '0;
      len_q  <= '0;
    end else if (advance_i) begin
      sum_q  <= sum_d;
      hist_q <= hist_d;
      cnt_q  <= cnt_d;
      len_q  <= len_d;
    end
  end

endmodule

// ===== design/alrc_out_reg.sv =====
// Output register stage driving the result stream.
module alrc_out_reg (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         load_i,
  input  alrc_pkg::result_t            result_i,
  output logic                         ready_o,
  output logic                         m_valid_o,
  input  logic                         m_ready_i,
  output logic [alrc_pkg::TdataW-1:0]  m_data_o,
  output logic                         m_last_o,
  output logic                         m_user_o
);

  logic              valid_q, valid_d;
  alrc_pkg::result_t res_q;

  assign ready_o = !valid_q || m_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (m_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= result_i;
    end
  end

  assign m_valid_o = valid_q;
  assign m_last_o  = res_q.frame_end;
  assign m_user_o  = res_q.payload_valid;
  assign m_data_o  = {7'd0, res_q.payload_length, res_q.computed_lrc,
                      res_q.received_lrc, res_q.frame_ok, res_q.payload_byte};

endmodule

// ===== design/ascii_lrc_frame_receiver.sv =====
// Top level of the ASCII LRC frame receiver with its configuration register.
//
// Input stream: one received character per transaction in s_axis_tdata[7:0].
// A colon restarts the frame; a line feed ends it. Every accepted character
// yields exactly one result transaction on the output stream.
// Output stream: m_axis_tuser flags a payload character in tdata[7:0];
// m_axis_tlast marks the line feed that closed a frame, with frame_ok,
// received_lrc, computed_lrc and payload_length in the upper tdata bits.
// The character passes from the input register into the result register, which
// drives the result transaction. Throughput: one character per cycle while the
// output accepts results; the history, sum and count are updated for each
// character as it moves into the result register.
// A stalled output holds its result; the input register still takes one more
// character, after which s_axis_tready drops until the output drains.
// Reset clears both stages and all frame state; accept_zero_lrc resets to 1.
// APB: register accept_zero_lrc at byte address 0, bit 0; pready always high.
`include "ascii_lrc_frame_receiver_defines.svh"

module ascii_lrc_frame_receiver (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [7:0] payload_byte, [8] frame_ok, [16:9] received_lrc,
  // [24:17] computed_lrc, [32:25] payload_length, [39:33] zero
  output logic [alrc_pkg::TdataW-1:0] m_axis_tdata,
  output logic        m_axis_tlast,   // frame_end
  output logic        m_axis_tuser,   // [0] payload_valid
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic              azl_q;
  logic              cfg_wr;
  logic              in_valid;
  logic [7:0]        in_byte;
  logic              out_ready;
  logic              advance;
  alrc_pkg::result_t result;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready &&
                  (paddr[2] == alrc_pkg::RegAcceptZeroLrc);
  assign prdata = (paddr[2] == alrc_pkg::RegAcceptZeroLrc) ? {31'd0, azl_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      azl_q <= 1'b1;
    end else if (cfg_wr) begin
      azl_q <= pwdata[0];
    end
  end

  assign advance = in_valid && out_ready;

  alrc_in_reg u_in (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .s_data_i  (s_axis_tdata),
    .advance_i (advance),
    .valid_o   (in_valid),
    .data_o    (in_byte)
  );

  alrc_core u_core (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .advance_i         (advance),
    .rx_byte_i         (in_byte),
    .accept_zero_lrc_i (azl_q),
    .result_o          (result)
  );

  alrc_out_reg u_out (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .load_i    (advance),
    .result_i  (result),
    .ready_o   (out_ready),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .m_data_o  (m_axis_tdata),
    .m_last_o  (m_axis_tlast),
    .m_user_o  (m_axis_tuser)
  );

  `ALRC_ASSERT(a_ok_needs_end, clk_i, rst_ni, (m_axis_tvalid && m_axis_tdata[8]) |-> m_axis_tlast)
  `ALRC_ASSERT_NEVER(a_payload_not_end, clk_i, rst_ni, m_axis_tvalid && m_axis_tuser && m_axis_tlast)
  `ALRC_ASSERT(a_full_stall, clk_i, rst_ni, (in_valid && m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)

endmodule

// ===== test/tb.sv =====
// Testbench for ascii_lrc_frame_receiver: random framed traffic with a predictor-backed scoreboard.
module tb;
  import alrc_pkg::*;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned HoldCycles = 80;
  localparam int unsigned SettleCycles = 6;
  localparam logic [7:0] Cr = 8'h0d;
  localparam logic [2:0] AzlAddr = 3'd0;
  localparam logic [2:0] SpareAddr = 3'd4;

  typedef enum {LrcRight, LrcZero, LrcWrong, LrcBadDigit} lrc_kind_e;

  class lrc_frame_scoreboard;
    result_t expected_q[$];
    logic accept_zero = 1'b1;
    logic [7:0] sum = '0;
    logic [7:0] hist [3] = '{default: '0};
    logic [1:0] hist_cnt = '0;
    logic [7:0] pay_cnt = '0;
    int errors = 0;
    int frames_closed = 0;
    int frames_good = 0;
    int payload_seen = 0;

    function void clear_frame();
      sum = '0;
      hist = '{default: '0};
      hist_cnt = '0;
      pay_cnt = '0;
    endfunction

    function void write_reg(int idx, logic [31:0] v);
      if (idx == RegAcceptZeroLrc) accept_zero = v[0];
    endfunction

    function bit hex_nibble(input logic [7:0] c, output logic [3:0] v);
      logic [7:0] d;
      d = '0;
      v = '0;
      if (c >= Ch0 && c <= Ch9) d = c - Ch0;
      else if (c >= ChLowA && c <= ChLowF) d = c - ChLowA + HexTen;
      else if (c >= ChUpA && c <= ChUpF) d = c - ChUpA + HexTen;
      else return 1'b0;
      v = d[3:0];
      return 1'b1;
    endfunction

    function void note_char(logic [7:0] c);
      result_t r;
      logic [3:0] hi, lo;
      bit hi_ok, lo_ok;
      r = '0;
      if (c == ChColon) begin
        clear_frame();
      end else if (c == ChLf) begin
        r.frame_end = 1'b1;
        r.computed_lrc = 8'd0 - sum;
        r.payload_length = pay_cnt;
        hi_ok = hex_nibble(hist[0], hi);
        lo_ok = hex_nibble(hist[1], lo);
        if (hist_cnt == HistFull && hi_ok && lo_ok) begin
          r.received_lrc = {hi, lo};
          r.frame_ok = (r.received_lrc == r.computed_lrc) ||
                       (accept_zero && r.received_lrc == 8'd0);
        end
        frames_closed++;
        if (r.frame_ok) frames_good++;
        clear_frame();
      end else begin
        if (hist_cnt == HistFull) begin
          r.payload_valid = 1'b1;
          r.payload_byte = hist[0];
          sum += hist[0];
          hist[0] = hist[1];
          hist[1] = hist[2];
          hist[2] = c;
          if (pay_cnt != CountMax) pay_cnt++;
          payload_seen++;
        end else begin
          hist[hist_cnt] = c;
          hist_cnt++;
        end
        r.computed_lrc = 8'd0 - sum;
        r.payload_length = pay_cnt;
      end
      expected_q.push_back(r);
    endfunction

    function void cmp(string field, logic [7:0] e, logic [7:0] a);
      if (a !== e) begin
        $error("%s: expected %0h, actual %0h", field, e, a);
        errors++;
      end
    endfunction

    function void check_result(result_t a, logic [6:0] pad);
      result_t e;
      if (expected_q.size() == 0) begin
        $error("result transaction with no character pending");
        errors++;
        return;
      end
      e = expected_q.pop_front();
      cmp("payload_valid", {7'd0, e.payload_valid}, {7'd0, a.payload_valid});
      cmp("payload_byte", e.payload_byte, a.payload_byte);
      cmp("frame_end", {7'd0, e.frame_end}, {7'd0, a.frame_end});
      cmp("frame_ok", {7'd0, e.frame_ok}, {7'd0, a.frame_ok});
      cmp("received_lrc", e.received_lrc, a.received_lrc);
      cmp("computed_lrc", e.computed_lrc, a.computed_lrc);
      cmp("payload_length", e.payload_length, a.payload_length);
      cmp("tdata_pad", 8'd0, {1'b0, pad});
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [7:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [TdataW-1:0] m_axis_tdata;
  logic m_axis_tlast;
  logic m_axis_tuser;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  lrc_frame_scoreboard sb = new;
  bit idle_on = 1'b1;
  bit hold_req = 1'b0;
  int n_sent = 0;
  int unsigned cycle_count = 0;

  logic [7:0] directed_chars [23] = '{
    ChColon, "0", "1", "0", "3", "3", "c", Cr, ChLf,
    ChColon, 8'hff, "0", "0", 8'h00, ChLf,
    ChColon, "A", "G", Cr, ChLf,
    ChColon, "a", ChLf
  };

  ascii_lrc_frame_receiver dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CycleLimit) begin
      $display("ascii_lrc_frame_receiver regression: fail");
      $finish;
    end
  end

  always @(posedge clk_i) begin : result_mon
    result_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.payload_valid = m_axis_tuser;
      got.payload_byte = m_axis_tdata[7:0];
      got.frame_end = m_axis_tlast;
      got.frame_ok = m_axis_tdata[8];
      got.received_lrc = m_axis_tdata[16:9];
      got.computed_lrc = m_axis_tdata[24:17];
      got.payload_length = m_axis_tdata[32:25];
      sb.check_result(got, m_axis_tdata[39:33]);
    end
  end

  // result sink: random stalls, plus one long hold-off on request
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (HoldCycles - 1) @(negedge clk_i);
        hold_req = 1'b0;
      end else begin
        m_axis_tready <= !(idle_on && $urandom_range(99) < 38);
      end
    end
  end

  function automatic logic [7:0] hex_ascii(input logic [3:0] nib, input bit lower);
    if (nib < 4'd10) return Ch0 + nib;
    return (lower ? ChLowA : ChUpA) + nib - HexTen;
  endfunction

  task automatic send_char(input logic [7:0] c);
    while (idle_on && $urandom_range(99) < 38) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
      s_axis_tdata <= 8'($urandom);
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= c;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_char(c);
    n_sent++;
  endtask

  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.write_reg(int'(addr >> 2), data);
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic check_azl_readback();
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= AzlAddr;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== {31'd0, sb.accept_zero}) begin
      $error("accept_zero_lrc readback: expected %0h, actual %0h",
             {31'd0, sb.accept_zero}, prdata);
      sb.errors++;
    end
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic send_frame(input int n_payload, input lrc_kind_e kind);
    logic [7:0] sum, c, lrc, hi_c, lo_c;
    bit lower;
    sum = '0;
    send_char(ChColon);
    repeat (n_payload) begin
      do c = 8'($urandom); while (c == ChColon || c == ChLf);
      sum += c;
      send_char(c);
    end
    case (kind)
      LrcRight: lrc = 8'd0 - sum;
      LrcZero:  lrc = 8'd0;
      default:  lrc = 8'($urandom);
    endcase
    lower = 1'($urandom_range(1));
    hi_c = hex_ascii(lrc[7:4], lower);
    lo_c = hex_ascii(lrc[3:0], lower);
    if (kind == LrcBadDigit) begin
      // 'G'..'Z' or a byte with the top bit set
      c = $urandom_range(1) ? 8'h47 + 8'($urandom_range(19)) : {1'b1, 7'($urandom)};
      if ($urandom_range(1)) hi_c = c;
      else lo_c = c;
    end
    send_char(hi_c);
    send_char(lo_c);
    if ($urandom_range(9) == 0) begin
      do c = 8'($urandom); while (c == ChColon || c == ChLf);
    end else begin
      c = Cr;
    end
    send_char(c);
    send_char(ChLf);
  endtask

  task automatic random_traffic(input int count);
    int stop, r, len;
    lrc_kind_e kind;
    stop = n_sent + count;
    while (n_sent < stop) begin
      if ($urandom_range(99) < 80) begin
        r = $urandom_range(99);
        kind = r < 55 ? LrcRight : r < 70 ? LrcZero : r < 85 ? LrcWrong : LrcBadDigit;
        len = $urandom_range(99) < 90 ? $urandom_range(16) : $urandom_range(60, 17);
        send_frame(len, kind);
      end else begin
        // broken traffic: stray colons, line feeds and raw bytes
        repeat ($urandom_range(8, 1)) begin
          r = $urandom_range(99);
          send_char(r < 20 ? ChColon : r < 40 ? ChLf : 8'($urandom));
        end
      end
    end
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    check_azl_readback();
    foreach (directed_chars[i]) send_char(directed_chars[i]);
    drain();

    apb_write(AzlAddr, 32'd0);
    check_azl_readback();
    idle_on = 1'b0;
    random_traffic(250);
    idle_on = 1'b1;
    random_traffic(250);
    drain();

    apb_write(AzlAddr, 32'd1);
    hold_req = 1'b1;
    random_traffic(300);
    send_frame(270, LrcRight);
    random_traffic(150);
    drain();

    apb_write(AzlAddr, 32'd0);
    apb_write(SpareAddr, 32'hffff_ffff);
    check_azl_readback();
    apb_write(AzlAddr, 32'hffff_ffff);
    check_azl_readback();
    random_traffic(250);
    send_frame(300, LrcZero);
    random_traffic(100);
    drain();

    $display("sent %0d characters over both accept_zero_lrc settings, %0d payload bytes",
             n_sent, sb.payload_seen);
    $display("closed %0d frames, %0d passed the LRC check, in %0d cycles",
             sb.frames_closed, sb.frames_good, cycle_count);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("ascii_lrc_frame_receiver regression: pass");
    end else begin
      $display("ascii_lrc_frame_receiver regression: fail");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+design
design/alrc_pkg.sv
design/alrc_in_reg.sv
design/alrc_core.sv
design/alrc_out_reg.sv
design/ascii_lrc_frame_receiver.sv
test/tb.sv
